// ===== src/offset_trace_bitflip_correction_sums_assert.svh =====
// Assertion macros shared by the offset-trace correction sums design.
`ifndef OFFSET_TRACE_BITFLIP_CORRECTION_SUMS_ASSERT_SVH
`define OFFSET_TRACE_BITFLIP_CORRECTION_SUMS_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OTBCS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define OTBCS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== src/otbcs_pkg.sv =====
// Package with the types, constants and saturation helpers of the correction sums block.
`timescale 1ns / 1ps

package otbcs_pkg;

    localparam int MAX_QUBITS = 10;
    localparam int ROW_BITS   = 12;
    localparam int OFFSET_W   = 12;
    localparam int QCOUNT_W   = 4;
    localparam int QW         = $clog2(MAX_QUBITS + 1);
    localparam int SUM_W      = ((MAX_QUBITS > OFFSET_W) ? MAX_QUBITS : OFFSET_W) + 1;
    localparam int DW         = (ROW_BITS > SUM_W) ? ROW_BITS : SUM_W;
    localparam int ELEM_W     = 32;
    localparam int ACC_W      = 48;
    localparam int OUT_W      = 40;
    localparam int FRAC_BITS  = 30;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 12;

    localparam logic [CFG_INDEX_W-1:0] REG_QUBIT_COUNT = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_OFFSET  = CFG_INDEX_W'(1);

    localparam logic signed [ACC_W:0] ONE_Q30 = (ACC_W + 1)'(1) << FRAC_BITS;

    typedef struct packed {
        logic [ROW_BITS-1:0]          row_index;
        logic [MAX_QUBITS-1:0]        col_index;
        logic signed [ELEM_W-1:0]     element_real;
        logic                         last_element;
    } item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] cost_value;
        logic signed [OUT_W-1:0] first_correction;
        logic signed [OUT_W-1:0] second_correction;
    } result_t;

    typedef struct packed {
        logic hit_diag;
        logic hit_one;
        logic hit_two;
    } hit_t;

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
        logic signed [ACC_W-1:0] r;
        if (v[ACC_W] == v[ACC_W-1]) begin
            r = v[ACC_W-1:0];
        end else begin
            r = {v[ACC_W], {(ACC_W-1){~v[ACC_W]}}};
        end
        return r;
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W:0] v);
        logic signed [OUT_W-1:0] r;
        if (v[ACC_W:OUT_W-1] == {(ACC_W-OUT_W+2){v[ACC_W]}}) begin
            r = v[OUT_W-1:0];
        end else begin
            r = {v[ACC_W], {(OUT_W-1){~v[ACC_W]}}};
        end
        return r;
    endfunction

endpackage

// ===== src/otbcs_classify.sv =====
// Classifier that sorts one matrix element into the diagonal or a bit-flip class, if any.
`timescale 1ns / 1ps

module otbcs_classify (
    input  logic [otbcs_pkg::ROW_BITS-1:0]   row_index,
    input  logic [otbcs_pkg::MAX_QUBITS-1:0] col_index,
    input  logic [otbcs_pkg::OFFSET_W-1:0]   row_offset,
    input  logic [otbcs_pkg::QW-1:0]         qubit_eff,
    output otbcs_pkg::hit_t                  hit
);

    logic [otbcs_pkg::SUM_W-1:0] col_sum;
    logic [otbcs_pkg::DW-1:0]    flip_mask;
    logic [otbcs_pkg::DW-1:0]    rest;
    logic [otbcs_pkg::DW-1:0]    rest2;
    logic                        col_ok;
    logic                        flip_small;

    assign col_sum    = otbcs_pkg::SUM_W'(col_index) + otbcs_pkg::SUM_W'(row_offset);
    assign flip_mask  = otbcs_pkg::DW'(row_index) ^ otbcs_pkg::DW'(col_sum);
    assign rest       = flip_mask & (flip_mask - otbcs_pkg::DW'(1));
    assign rest2      = rest & (rest - otbcs_pkg::DW'(1));
    assign col_ok     = ((col_index >> qubit_eff) == '0);
    assign flip_small = ((flip_mask >> qubit_eff) == '0);

    always_comb
    begin
        hit.hit_diag = col_ok && (flip_mask == '0);
        hit.hit_one  = col_ok && flip_small && (flip_mask != '0) && (rest == '0);
        hit.hit_two  = col_ok && flip_small && (rest != '0) && (rest2 == '0);
    end

endmodule

// ===== src/offset_trace_bitflip_correction_sums.sv =====
// Top level of the offset-trace and bit-flip correction sums block.
// Matrix elements arrive on the item channel (item_valid, item_stall, item), one
// transfer per element, in any order. Each element is registered, classified against
// the shifted diagonal and added to at most one of three saturating 48-bit sums.
// An element with last_element set closes the matrix: the block hands one result on
// the result channel (result_valid, result_stall, result) with the cost value and the
// two correction terms, and all three sums start again from zero.
// One element is taken per clock cycle while item_stall is low (single accumulate stage).
// A last element passes from the input register into the final-sum register and then,
// through the shift and saturate logic, into the result register; stalls can hold it.
// When the receiver stalls, ordinary elements keep flowing into the sums; item_stall
// rises only when a last element finds both the final-sum stage and the result
// register occupied.
// The cfg port (cfg_valid, cfg_ready, cfg_index, cfg_data) writes qubit_count at index
// zero and row_offset at index one; cfg_ready is always high and other indices are
// ignored. The user must write configuration only while the block is idle; unchecked.
// Reset clears the sums and the pipeline, sets qubit_count to one and row_offset to zero.
`timescale 1ns / 1ps

module offset_trace_bitflip_correction_sums (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  otbcs_pkg::item_t                      item,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output otbcs_pkg::result_t                    result,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [otbcs_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [otbcs_pkg::CFG_DATA_W-1:0]      cfg_data
);

`include "offset_trace_bitflip_correction_sums_assert.svh"

    logic [otbcs_pkg::QCOUNT_W-1:0]  qubit_count_reg;
    logic [otbcs_pkg::OFFSET_W-1:0]  row_offset_reg;
    logic [otbcs_pkg::QW-1:0]        qubit_eff;

    otbcs_pkg::item_t                s1_reg;
    logic                            s1_valid_reg;
    otbcs_pkg::hit_t                 hit;

    logic signed [otbcs_pkg::ACC_W-1:0] diag_acc_reg;
    logic signed [otbcs_pkg::ACC_W-1:0] one_acc_reg;
    logic signed [otbcs_pkg::ACC_W-1:0] two_acc_reg;
    logic signed [otbcs_pkg::ACC_W-1:0] diag_acc_next;
    logic signed [otbcs_pkg::ACC_W-1:0] one_acc_next;
    logic signed [otbcs_pkg::ACC_W-1:0] two_acc_next;
    logic signed [otbcs_pkg::ACC_W:0]   elem_ext;

    logic signed [otbcs_pkg::ACC_W-1:0] fin_diag_reg;
    logic signed [otbcs_pkg::ACC_W-1:0] fin_one_reg;
    logic signed [otbcs_pkg::ACC_W-1:0] fin_two_reg;
    logic                               fin_valid_reg;

    logic signed [otbcs_pkg::ACC_W-1:0] diag_shift;
    logic signed [otbcs_pkg::ACC_W-1:0] one_shift;
    logic signed [otbcs_pkg::ACC_W-1:0] two_shift;
    otbcs_pkg::result_t                 result_next;
    otbcs_pkg::result_t                 result_reg;
    logic                               result_valid_reg;

    logic out_free;
    logic fin_move;
    logic fin_free;
    logic s1_go;
    logic s1_last_go;
    logic item_take;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            qubit_count_reg <= otbcs_pkg::QCOUNT_W'(1);
            row_offset_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                otbcs_pkg::REG_QUBIT_COUNT: qubit_count_reg <= cfg_data[otbcs_pkg::QCOUNT_W-1:0];
                otbcs_pkg::REG_ROW_OFFSET:  row_offset_reg  <= cfg_data[otbcs_pkg::OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    // A qubit count of zero acts as one, and a count above the maximum acts as the maximum.
    always_comb
    begin
        priority if (qubit_count_reg == '0) begin
            qubit_eff = otbcs_pkg::QW'(1);
        end else if (32'(qubit_count_reg) > otbcs_pkg::MAX_QUBITS) begin
            qubit_eff = otbcs_pkg::QW'(otbcs_pkg::MAX_QUBITS);
        end else begin
            qubit_eff = otbcs_pkg::QW'(qubit_count_reg);
        end
    end

    // Flow control: only a last element needs room further down the pipeline.
    assign out_free   = !result_valid_reg || !result_stall;
    assign fin_move   = fin_valid_reg && out_free;
    assign fin_free   = !fin_valid_reg || out_free;
    assign s1_go      = s1_valid_reg && (!s1_reg.last_element || fin_free);
    assign s1_last_go = s1_go && s1_reg.last_element;
    assign item_stall = s1_valid_reg && !s1_go;
    assign item_take  = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (item_take) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_go) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take) begin
            s1_reg <= item;
        end
    end

    otbcs_classify u_classify (
        .row_index  (s1_reg.row_index),
        .col_index  (s1_reg.col_index),
        .row_offset (row_offset_reg),
        .qubit_eff  (qubit_eff),
        .hit        (hit)
    );

    assign elem_ext = (otbcs_pkg::ACC_W + 1)'(s1_reg.element_real);

    always_comb
    begin
        diag_acc_next = diag_acc_reg;
        one_acc_next  = one_acc_reg;
        two_acc_next  = two_acc_reg;
        if (hit.hit_diag) begin
            diag_acc_next = otbcs_pkg::sat_acc((otbcs_pkg::ACC_W + 1)'(diag_acc_reg) + elem_ext);
        end
        if (hit.hit_one) begin
            one_acc_next = otbcs_pkg::sat_acc((otbcs_pkg::ACC_W + 1)'(one_acc_reg) + elem_ext);
        end
        if (hit.hit_two) begin
            two_acc_next = otbcs_pkg::sat_acc((otbcs_pkg::ACC_W + 1)'(two_acc_reg) + elem_ext);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            diag_acc_reg <= '0;
            one_acc_reg  <= '0;
            two_acc_reg  <= '0;
        end else if (s1_last_go) begin
            diag_acc_reg <= '0;
            one_acc_reg  <= '0;
            two_acc_reg  <= '0;
        end else if (s1_go) begin
            diag_acc_reg <= diag_acc_next;
            one_acc_reg  <= one_acc_next;
            two_acc_reg  <= two_acc_next;
        end
    end

    // Final sums of a closed matrix wait here for the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fin_valid_reg <= 1'b0;
        end else if (s1_last_go) begin
            fin_valid_reg <= 1'b1;
        end else if (fin_move) begin
            fin_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_last_go) begin
            fin_diag_reg <= diag_acc_next;
            fin_one_reg  <= one_acc_next;
            fin_two_reg  <= two_acc_next;
        end
    end

    // Division by the column count is an arithmetic shift, rounding toward minus infinity.
    assign diag_shift = fin_diag_reg >>> qubit_eff;
    assign one_shift  = fin_one_reg >>> qubit_eff;
    assign two_shift  = fin_two_reg >>> qubit_eff;

    always_comb
    begin
        result_next.cost_value = otbcs_pkg::sat_out(
            otbcs_pkg::ONE_Q30 - (otbcs_pkg::ACC_W + 1)'(diag_shift));
        result_next.first_correction  = otbcs_pkg::sat_out((otbcs_pkg::ACC_W + 1)'(one_shift));
        result_next.second_correction = otbcs_pkg::sat_out((otbcs_pkg::ACC_W + 1)'(two_shift));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            result_valid_reg <= 1'b0;
        end else if (fin_move) begin
            result_valid_reg <= 1'b1;
        end else if (!result_stall) begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_move) begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `OTBCS_ASSERT_NEXT(a_last_fills_final, s1_last_go, fin_valid_reg)
    `OTBCS_ASSERT_NEXT(a_last_clears_sums, s1_last_go,
        (diag_acc_reg == '0) && (one_acc_reg == '0) && (two_acc_reg == '0))
    `OTBCS_ASSERT_NOW(a_stall_only_on_full, item_stall,
        s1_valid_reg && s1_reg.last_element && fin_valid_reg && result_valid_reg)
    `OTBCS_ASSERT_NEXT(a_final_reaches_result, fin_move, result_valid_reg)

endmodule
